// ----- rtl/core/rmj_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_pkg: shared types and constants of the radar measurement Jacobian
// Widths, register map, pipeline depths and the output clipping function.
// ----------------------------------------------------------------------------
package rmj_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DATA_W        = 32;
	localparam int Q_W           = 32;
	localparam int LIMIT_W       = 31;
	localparam int ADDR_W        = 3;
	localparam int SQRT_STEPS    = 32;
	// input regs, squares, sums, root, two product stages, divide, output
	localparam int LATENCY       = 3 + SQRT_STEPS + 2 + Q_W + 1;

	// register index carried in paddr above the byte offset
	localparam logic [ADDR_W-3:0] REG_NEAR_LIMIT = '0;

	localparam logic [Q_W-1:0] MAX_POS = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic [Q_W-1:0] MIN_MAG = {1'b1, {(Q_W-1){1'b0}}};

	// per-request status that rides along the pipeline
	typedef struct packed {
		logic near;
		logic neg_x;
		logic neg_y;
		logic pos_y;
		logic neg_rx;
		logic neg_ry;
	} rmj_tag_t;

	// operands held while the root is worked out
	typedef struct packed {
		logic [DATA_W-1:0]   mx;
		logic [DATA_W-1:0]   my;
		logic [2*DATA_W-1:0] rho;
		logic [2*DATA_W-1:0] cmag;
		rmj_tag_t            tag;
	} rmj_carry_t;

	// apply sign and clip magnitude; msb of the result flags clipping
	function automatic logic [Q_W:0] rmj_clip(input logic neg, input logic [Q_W-1:0] q,
			input logic ovf);
		logic [Q_W:0] res;
		if (neg) begin
			if (ovf || q > MIN_MAG) res = {1'b1, MIN_MAG};
			else res = {1'b0, -q};
		end else begin
			if (ovf || q > MAX_POS) res = {1'b1, MAX_POS};
			else res = {1'b0, q};
		end
		return res;
	endfunction

endpackage

// ----- rtl/core/rmj_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_div: pipelined restoring divider
// One quotient bit per stage, Q_W stages; flags quotients of 2^Q_W or more.
// ----------------------------------------------------------------------------
module rmj_div #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 32
) (
	input  logic                      clk,
	input  logic [NUM_W-1:0]          num,
	input  logic [DEN_W-1:0]          den,
	output logic [rmj_pkg::Q_W-1:0]   quo,
	output logic                      ovf
);
	import rmj_pkg::*;

	localparam int UP_W  = NUM_W - Q_W;
	localparam int CMP_W = (UP_W > DEN_W) ? UP_W : DEN_W;

	logic [DEN_W-1:0] rem_sk [1:Q_W];
	logic [DEN_W-1:0] den_sk [1:Q_W];
	logic [Q_W-1:0]   low_sk [1:Q_W];
	logic [Q_W-1:0]   quo_sk [1:Q_W];
	logic             ovf_sk [1:Q_W];

	// upper numerator part seeds the remainder; overflow when it reaches den
	logic [CMP_W-1:0] up_ext;
	assign up_ext = CMP_W'(num[NUM_W-1:Q_W]);

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		logic [DEN_W-1:0] rem_in, den_in;
		logic [Q_W-1:0]   low_in, quo_in;
		logic             ovf_in;
		logic [DEN_W:0]   trial;

		if (k == 0) begin : g_first
			assign rem_in = up_ext[DEN_W-1:0];
			assign den_in = den;
			assign low_in = num[Q_W-1:0];
			assign quo_in = '0;
			assign ovf_in = (up_ext >= CMP_W'(den));
		end else begin : g_next
			assign rem_in = rem_sk[k];
			assign den_in = den_sk[k];
			assign low_in = low_sk[k];
			assign quo_in = quo_sk[k];
			assign ovf_in = ovf_sk[k];
		end

		assign trial = {rem_in, low_in[Q_W-1]};

		// compare and subtract, one bit
		always_ff @(posedge clk) begin
			if (trial >= {1'b0, den_in}) begin
				rem_sk[k+1] <= DEN_W'(trial - {1'b0, den_in});
				quo_sk[k+1] <= {quo_in[Q_W-2:0], 1'b1};
			end else begin
				rem_sk[k+1] <= trial[DEN_W-1:0];
				quo_sk[k+1] <= {quo_in[Q_W-2:0], 1'b0};
			end
			den_sk[k+1] <= den_in;
			low_sk[k+1] <= low_in << 1;
			ovf_sk[k+1] <= ovf_in;
		end
	end

	assign quo = quo_sk[Q_W];
	assign ovf = ovf_sk[Q_W];

endmodule

// ----- rtl/core/radar_measurement_jacobian.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radar_measurement_jacobian: EKF radar measurement Jacobian, fixed point
// Six distinct entries of the 3x4 Jacobian from (px, py, vx, vy).
//
//  channel   handshake                      payload
//  -------   -----------------------------  ---------------------------------
//  request   start high, busy low           pos_x pos_y vel_x vel_y
//  result    done, one cycle, no backpress  range_dx/dy bearing_dx/dy
//                                            rate_dx/dy near_zero saturated
//  config    APB write, pready always high  near_zero_limit at byte 0
//
// One request per cycle; busy stays low. Each result passes through 3 front
// stages, 32 root stages, 2 product stages, 32 divider stages and the output
// stage. The pipeline never stalls.
// Reset clears valid bits and loads near_zero_limit with round(0.01 * 2^F).
// ----------------------------------------------------------------------------
module radar_measurement_jacobian #(
	parameter int FRAC_BITS = rmj_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [rmj_pkg::DATA_W-1:0] pos_x,
	input  logic signed [rmj_pkg::DATA_W-1:0] pos_y,
	input  logic signed [rmj_pkg::DATA_W-1:0] vel_x,
	input  logic signed [rmj_pkg::DATA_W-1:0] vel_y,
	output logic                              done,
	output logic signed [rmj_pkg::Q_W-1:0]    range_dx,
	output logic signed [rmj_pkg::Q_W-1:0]    range_dy,
	output logic signed [rmj_pkg::Q_W-1:0]    bearing_dx,
	output logic signed [rmj_pkg::Q_W-1:0]    bearing_dy,
	output logic signed [rmj_pkg::Q_W-1:0]    rate_dx,
	output logic signed [rmj_pkg::Q_W-1:0]    rate_dy,
	output logic                              near_zero,
	output logic                              saturated,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rmj_pkg::ADDR_W-1:0]        paddr,
	input  logic [rmj_pkg::DATA_W-1:0]        pwdata,
	output logic [rmj_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);
	import rmj_pkg::*;

	localparam int W2 = 2 * DATA_W;
	localparam int W3 = 3 * DATA_W;
	localparam logic [LIMIT_W-1:0] LIMIT_RST =
		LIMIT_W'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

	// ---------------- configuration register ----------------
	logic [LIMIT_W-1:0] limit_q;
	logic               reg_hit;

	assign reg_hit = (paddr[ADDR_W-1:2] == REG_NEAR_LIMIT);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? {{(DATA_W-LIMIT_W){1'b0}}, limit_q} : '0;
	assign busy    = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= LIMIT_RST;
		else if (psel && penable && pwrite && pready && reg_hit) limit_q <= pwdata[LIMIT_W-1:0];
	end

	// ---------------- valid bits ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, done_q;
	logic v_sq [1:SQRT_STEPS];
	logic v_dv [1:Q_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			done_q <= 1'b0;
			for (int k = 1; k <= SQRT_STEPS; k++) v_sq[k] <= 1'b0;
			for (int k = 1; k <= Q_W; k++) v_dv[k] <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_sq[1] <= v_s3;
			for (int k = 2; k <= SQRT_STEPS; k++) v_sq[k] <= v_sq[k-1];
			v_s4 <= v_sq[SQRT_STEPS];
			v_s5 <= v_s4;
			v_dv[1] <= v_s5;
			for (int k = 2; k <= Q_W; k++) v_dv[k] <= v_dv[k-1];
			done_q <= v_dv[Q_W];
		end
	end

	// ---------------- stage 1: capture request ----------------
	logic signed [DATA_W-1:0] px_s1, py_s1, vx_s1, vy_s1;

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			px_s1 <= pos_x;
			py_s1 <= pos_y;
			vx_s1 <= vel_x;
			vy_s1 <= vel_y;
		end
	end

	// ---------------- stage 2: magnitudes and products ----------------
	logic [DATA_W-1:0]        mx_c, my_c;
	logic [DATA_W-1:0]        mx_s2, my_s2;
	logic [W2-1:0]            mx2_s2, my2_s2;
	logic signed [W2-1:0]     vxpy_s2, vypx_s2;
	logic                     negx_s2, negy_s2, posy_s2;

	assign mx_c = px_s1[DATA_W-1] ? DATA_W'(-px_s1) : px_s1;
	assign my_c = py_s1[DATA_W-1] ? DATA_W'(-py_s1) : py_s1;

	always_ff @(posedge clk) begin
		mx_s2   <= mx_c;
		my_s2   <= my_c;
		mx2_s2  <= mx_c * mx_c;
		my2_s2  <= my_c * my_c;
		vxpy_s2 <= vx_s1 * py_s1;
		vypx_s2 <= vy_s1 * px_s1;
		negx_s2 <= px_s1[DATA_W-1];
		negy_s2 <= py_s1[DATA_W-1];
		posy_s2 <= !py_s1[DATA_W-1] && (py_s1 != '0);
	end

	// ---------------- stage 3: squared range, cross term, threshold ----------------
	logic [W2-1:0]        rho_c;
	logic signed [W2:0]   cr_c;
	rmj_carry_t           carry_s3;

	assign rho_c = mx2_s2 + my2_s2;
	assign cr_c  = (W2+1)'(vxpy_s2) - (W2+1)'(vypx_s2);

	always_ff @(posedge clk) begin
		carry_s3.mx         <= mx_s2;
		carry_s3.my         <= my_s2;
		carry_s3.rho        <= rho_c;
		carry_s3.cmag       <= cr_c[W2] ? W2'(-cr_c) : cr_c[W2-1:0];
		carry_s3.tag.near   <= (rho_c == '0) || (rho_c < (W2'(limit_q) << FRAC_BITS));
		carry_s3.tag.neg_x  <= negx_s2;
		carry_s3.tag.neg_y  <= negy_s2;
		carry_s3.tag.pos_y  <= posy_s2;
		carry_s3.tag.neg_rx <= negy_s2 != cr_c[W2];
		carry_s3.tag.neg_ry <= negx_s2 == cr_c[W2];
	end

	// ---------------- root: one result bit per stage ----------------
	logic [W2-1:0] sq_v_sq [1:SQRT_STEPS-1];
	logic [W2-1:0] sq_r_sq [1:SQRT_STEPS-1];
	rmj_carry_t    cr_sq   [1:SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		localparam logic [W2-1:0] BIT = W2'(1) << (W2 - 2 - 2 * k);
		logic [W2-1:0] v_in, r_in, trial;

		if (k == 0) begin : g_first
			assign v_in = carry_s3.rho;
			assign r_in = '0;
		end else begin : g_next
			assign v_in = sq_v_sq[k];
			assign r_in = sq_r_sq[k];
		end

		assign trial = r_in + BIT;

		if (k < SQRT_STEPS - 1) begin : g_mid
			always_ff @(posedge clk) begin
				if (v_in >= trial) begin
					sq_v_sq[k+1] <= v_in - trial;
					sq_r_sq[k+1] <= (r_in >> 1) + BIT;
				end else begin
					sq_v_sq[k+1] <= v_in;
					sq_r_sq[k+1] <= r_in >> 1;
				end
			end
		end else begin : g_last
			// final stage lands in the root register below
			logic [DATA_W-1:0] root;
			assign root = (v_in >= trial) ? DATA_W'((r_in >> 1) + BIT) : DATA_W'(r_in >> 1);
		end
	end

	always_ff @(posedge clk) begin
		cr_sq[1] <= carry_s3;
		for (int k = 2; k <= SQRT_STEPS; k++) cr_sq[k] <= cr_sq[k-1];
	end

	// root register ends the root stages
	logic [DATA_W-1:0] root_q;
	always_ff @(posedge clk) root_q <= g_sqrt[SQRT_STEPS-1].g_last.root;

	// ---------------- stage 4: partial products ----------------
	rmj_carry_t        cr_s4;
	logic [DATA_W-1:0] r_s4;
	logic [W2-1:0]     cube_lo_s4, cube_hi_s4, ym_lo_s4, ym_hi_s4, xm_lo_s4, xm_hi_s4;

	// root_q and the last carry slot hold the same request
	always_ff @(posedge clk) begin
		cr_s4      <= cr_sq[SQRT_STEPS];
		r_s4       <= root_q;
		cube_lo_s4 <= cr_sq[SQRT_STEPS].rho[DATA_W-1:0] * root_q;
		cube_hi_s4 <= cr_sq[SQRT_STEPS].rho[W2-1:DATA_W] * root_q;
		ym_lo_s4   <= cr_sq[SQRT_STEPS].cmag[DATA_W-1:0] * cr_sq[SQRT_STEPS].my;
		ym_hi_s4   <= cr_sq[SQRT_STEPS].cmag[W2-1:DATA_W] * cr_sq[SQRT_STEPS].my;
		xm_lo_s4   <= cr_sq[SQRT_STEPS].cmag[DATA_W-1:0] * cr_sq[SQRT_STEPS].mx;
		xm_hi_s4   <= cr_sq[SQRT_STEPS].cmag[W2-1:DATA_W] * cr_sq[SQRT_STEPS].mx;
	end

	// ---------------- stage 5: sum partial products ----------------
	rmj_carry_t        cr_s5;
	logic [DATA_W-1:0] r_s5;
	logic [W3-1:0]     cube_s5, ym_s5, xm_s5;

	always_ff @(posedge clk) begin
		cr_s5   <= cr_s4;
		r_s5    <= r_s4;
		cube_s5 <= W3'(cube_lo_s4) + {cube_hi_s4, {DATA_W{1'b0}}};
		ym_s5   <= W3'(ym_lo_s4) + {ym_hi_s4, {DATA_W{1'b0}}};
		xm_s5   <= W3'(xm_lo_s4) + {xm_hi_s4, {DATA_W{1'b0}}};
	end

	// ---------------- dividers ----------------
	logic [Q_W-1:0] q_rdx, q_rdy, q_bdx, q_bdy, q_tdx, q_tdy;
	logic           o_rdx, o_rdy, o_bdx, o_bdy, o_tdx, o_tdy;

	rmj_div #(.NUM_W(DATA_W + FRAC_BITS), .DEN_W(DATA_W)) u_div_rdx (
		.clk(clk), .num({cr_s5.mx, {FRAC_BITS{1'b0}}}), .den(r_s5), .quo(q_rdx), .ovf(o_rdx));
	rmj_div #(.NUM_W(DATA_W + FRAC_BITS), .DEN_W(DATA_W)) u_div_rdy (
		.clk(clk), .num({cr_s5.my, {FRAC_BITS{1'b0}}}), .den(r_s5), .quo(q_rdy), .ovf(o_rdy));
	rmj_div #(.NUM_W(DATA_W + 2 * FRAC_BITS), .DEN_W(W2)) u_div_bdx (
		.clk(clk), .num({cr_s5.my, {(2*FRAC_BITS){1'b0}}}), .den(cr_s5.rho),
		.quo(q_bdx), .ovf(o_bdx));
	rmj_div #(.NUM_W(DATA_W + 2 * FRAC_BITS), .DEN_W(W2)) u_div_bdy (
		.clk(clk), .num({cr_s5.mx, {(2*FRAC_BITS){1'b0}}}), .den(cr_s5.rho),
		.quo(q_bdy), .ovf(o_bdy));
	rmj_div #(.NUM_W(W3 + FRAC_BITS), .DEN_W(W3)) u_div_tdx (
		.clk(clk), .num({ym_s5, {FRAC_BITS{1'b0}}}), .den(cube_s5), .quo(q_tdx), .ovf(o_tdx));
	rmj_div #(.NUM_W(W3 + FRAC_BITS), .DEN_W(W3)) u_div_tdy (
		.clk(clk), .num({xm_s5, {FRAC_BITS{1'b0}}}), .den(cube_s5), .quo(q_tdy), .ovf(o_tdy));

	rmj_tag_t tag_dv [1:Q_W];
	always_ff @(posedge clk) begin
		tag_dv[1] <= cr_s5.tag;
		for (int k = 2; k <= Q_W; k++) tag_dv[k] <= tag_dv[k-1];
	end

	// ---------------- stage 6: sign, clip, zeroing ----------------
	rmj_tag_t       tg;
	logic [Q_W:0]   c_rdx, c_rdy, c_bdx, c_bdy, c_tdx, c_tdy;
	logic [Q_W-1:0] rdx_s6, rdy_s6, bdx_s6, bdy_s6, tdx_s6, tdy_s6;
	logic           near_s6, sat_s6;

	assign tg    = tag_dv[Q_W];
	assign c_rdx = rmj_clip(tg.neg_x, q_rdx, o_rdx);
	assign c_rdy = rmj_clip(tg.neg_y, q_rdy, o_rdy);
	assign c_bdx = rmj_clip(tg.pos_y, q_bdx, o_bdx);
	assign c_bdy = rmj_clip(tg.neg_x, q_bdy, o_bdy);
	assign c_tdx = rmj_clip(tg.neg_rx, q_tdx, o_tdx);
	assign c_tdy = rmj_clip(tg.neg_ry, q_tdy, o_tdy);

	always_ff @(posedge clk) begin
		rdx_s6  <= tg.near ? '0 : c_rdx[Q_W-1:0];
		rdy_s6  <= tg.near ? '0 : c_rdy[Q_W-1:0];
		bdx_s6  <= tg.near ? '0 : c_bdx[Q_W-1:0];
		bdy_s6  <= tg.near ? '0 : c_bdy[Q_W-1:0];
		tdx_s6  <= tg.near ? '0 : c_tdx[Q_W-1:0];
		tdy_s6  <= tg.near ? '0 : c_tdy[Q_W-1:0];
		near_s6 <= tg.near;
		sat_s6  <= !tg.near && (c_rdx[Q_W] || c_rdy[Q_W] || c_bdx[Q_W] ||
			c_bdy[Q_W] || c_tdx[Q_W] || c_tdy[Q_W]);
	end

	assign done       = done_q;
	assign range_dx   = rdx_s6;
	assign range_dy   = rdy_s6;
	assign bearing_dx = bdx_s6;
	assign bearing_dy = bdy_s6;
	assign rate_dx    = tdx_s6;
	assign rate_dy    = tdy_s6;
	assign near_zero  = near_s6;
	assign saturated  = sat_s6;

endmodule

// ----- rtl/core/rmj_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_check: port-level checks of the radar measurement Jacobian
// Fixed latency, result origin, zeroed entries and range-term bounds.
// ----------------------------------------------------------------------------
module rmj_check #(
	parameter int FRAC_BITS = rmj_pkg::FRAC_BITS_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic signed [rmj_pkg::Q_W-1:0]    range_dx,
	input logic signed [rmj_pkg::Q_W-1:0]    range_dy,
	input logic signed [rmj_pkg::Q_W-1:0]    bearing_dx,
	input logic signed [rmj_pkg::Q_W-1:0]    bearing_dy,
	input logic signed [rmj_pkg::Q_W-1:0]    rate_dx,
	input logic signed [rmj_pkg::Q_W-1:0]    rate_dy,
	input logic                              near_zero,
	input logic                              saturated
);
	import rmj_pkg::*;

	localparam logic signed [Q_W-1:0] ONE = Q_W'(1) << FRAC_BITS;

	// every request gives a result after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result missing after request");

	// no result without a request
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without request");

	// near range zeroes all entries and never reports clipping
	a_near: assert property (@(posedge clk) disable iff (!arst_n)
		(done && near_zero) |-> (range_dx == '0 && range_dy == '0 && bearing_dx == '0 &&
			bearing_dy == '0 && rate_dx == '0 && rate_dy == '0 && !saturated))
		else $error("near range result not zeroed");

	// unit direction terms stay within one
	a_unit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (range_dx <= ONE && range_dx >= -ONE && range_dy <= ONE && range_dy >= -ONE))
		else $error("direction term out of range");

endmodule

bind radar_measurement_jacobian rmj_check #(.FRAC_BITS(FRAC_BITS)) u_rmj_check (.*);
